// File: hdl/lpht_pkg.sv
`timescale 1ns / 1ps
package lpht_pkg;

	localparam int ACT_W      = 2;
	localparam int KEY_W      = 31;
	localparam int DATA_W     = 32;
	localparam int STAT_W     = 2;
	localparam int TOTAL_W    = 7;
	localparam int ENTRY_W    = 1 + KEY_W + DATA_W;
	localparam int IN_TDATA_W = 64;
	localparam int OUT_TDATA_W = 40;
	localparam int SLOTS_DEF  = 64;

	localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

	typedef struct packed {
		logic load;      // latch the accepted request
		logic mod_step;  // one step of the key reduction
		logic home;      // set up the probe at the home slot
		logic probe;     // probe pipeline runs
		logic clr;       // clearing pass write
		logic wr;        // write back the found slot
		logic emit;      // load the result register
	} cmd_t;

	typedef struct packed {
		logic mod_done;
		logic clr_last;
		logic hit;
		logic last;
		logic is_ins;
		logic is_del;
	} sts_t;

endpackage

// File: hdl/lpht_ram.sv
`timescale 1ns / 1ps
module lpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/lpht_dp.sv
`timescale 1ns / 1ps
module lpht_dp import lpht_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [ACT_W-1:0]       in_tuser,
	input  logic [IN_TDATA_W-1:0]  in_tdata,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	output logic [STAT_W-1:0]      out_tuser,
	output logic [OUT_TDATA_W-1:0] out_tdata
);

	localparam int AW      = $clog2(SLOTS);
	localparam int CW      = $clog2(SLOTS + 1);
	localparam int RECIP_W = 32;
	localparam int PROD_W  = KEY_W + RECIP_W;
	localparam int QUO_W   = RECIP_W - AW;
	localparam bit POW2    = ((SLOTS & (SLOTS - 1)) == 0);
	localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);
	// ceil(2^(KEY_W+AW) / SLOTS); key * RECIP >> (KEY_W+AW) is the exact quotient for any key
	localparam logic [63:0] RECIP64 =
		((64'd1 << (KEY_W + AW)) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP64);

	logic [ACT_W-1:0]   act_q;
	logic [KEY_W-1:0]   key_q;
	logic [DATA_W-1:0]  val_q;
	logic [KEY_W-1:0]   rem_q;
	logic               step_q;
	logic [PROD_W-1:0]  prod_q;
	logic [AW-1:0]      idx_q;
	logic [CW-1:0]      issued_q;
	logic [CW-1:0]      chk_q;
	logic [CW-1:0]      cnt_q;
	logic               rd_vld_s1;
	logic [AW-1:0]      addr_s1;
	logic [AW-1:0]      hit_addr_q;
	logic               found_q;
	logic               empty_q;
	logic [DATA_W-1:0]  data_q;
	logic [STAT_W-1:0]  out_status_q;
	logic [DATA_W-1:0]  out_value_q;
	logic [TOTAL_W-1:0] out_total_q;

	logic [QUO_W-1:0]   quo_w;
	logic [KEY_W-1:0]   qmul_w;
	logic [ENTRY_W-1:0] rd_entry;
	logic               rd_valid;
	logic [KEY_W-1:0]   rd_key;
	logic [DATA_W-1:0]  rd_data;
	logic               is_ins;
	logic               is_del;
	logic               match;
	logic               stop;
	logic               issue;
	logic [AW-1:0]      idx_next;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;

	// key mod SLOTS: reciprocal multiply, then key - quotient * SLOTS
	assign quo_w  = prod_q[PROD_W-1:KEY_W+AW];
	assign qmul_w = KEY_W'(quo_w) * KEY_W'(SLOTS);

	assign rd_valid = rd_entry[ENTRY_W-1];
	assign rd_key   = rd_entry[KEY_W+DATA_W-1:DATA_W];
	assign rd_data  = rd_entry[DATA_W-1:0];

	assign is_ins = (act_q == ACT_INSERT);
	assign is_del = (act_q == ACT_DELETE);
	assign match  = rd_valid && (rd_key == key_q);
	// insert also stops on the first empty slot
	assign stop   = rd_vld_s1 && (match || (is_ins && !rd_valid));
	assign issue  = cmd.probe && (issued_q != CW'(SLOTS));
	assign idx_next = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;

	assign sts.mod_done = POW2 || (step_q == 1'b0);
	assign sts.clr_last = (idx_q == LAST_IDX);
	assign sts.hit      = stop;
	assign sts.last     = rd_vld_s1 && (chk_q == CW'(SLOTS - 1));
	assign sts.is_ins   = is_ins;
	assign sts.is_del   = is_del;

	assign ram_we    = cmd.clr || cmd.wr;
	assign ram_waddr = cmd.clr ? idx_q : hit_addr_q;
	assign ram_wdata = (cmd.clr || is_del) ? '0 : {1'b1, key_q, val_q};

	lpht_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.home) begin
				idx_q <= rem_q[AW-1:0];
			end else if (cmd.clr || issue) begin
				idx_q <= idx_next;
			end
			if (cmd.wr) begin
				if (is_ins && empty_q) begin
					cnt_q <= cnt_q + 1'b1;
				end else if (is_del && (cnt_q != '0)) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= in_tuser;
			key_q   <= in_tdata[KEY_W-1:0];
			val_q   <= in_tdata[KEY_W+DATA_W-1:KEY_W];
			rem_q   <= in_tdata[KEY_W-1:0];
			step_q  <= 1'b1;
			found_q <= 1'b0;
		end
		if (cmd.mod_step && !POW2) begin
			if (step_q) begin
				prod_q <= PROD_W'(key_q) * PROD_W'(RECIP);
				step_q <= 1'b0;
			end else begin
				rem_q <= key_q - qmul_w;
			end
		end
		if (cmd.home) begin
			issued_q  <= '0;
			chk_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end
		if (cmd.probe) begin
			rd_vld_s1 <= issue;
			addr_s1   <= idx_q;
			if (issue) begin
				issued_q <= issued_q + 1'b1;
			end
			if (rd_vld_s1) begin
				chk_q <= chk_q + 1'b1;
			end
			if (stop) begin
				found_q    <= 1'b1;
				hit_addr_q <= addr_s1;
				empty_q    <= !rd_valid;
				data_q     <= rd_data;
			end
		end
		if (cmd.emit) begin
			out_status_q <= found_q ? STAT_OK : (is_ins ? STAT_FULL : STAT_ABSENT);
			out_value_q  <= (found_q && !is_ins && !is_del) ? data_q : '0;
			out_total_q  <= TOTAL_W'(cnt_q);
		end
	end

	assign out_tuser = out_status_q;
	assign out_tdata = {1'b0, out_total_q, out_value_q};

endmodule

// File: hdl/lpht_ctrl.sv
`timescale 1ns / 1ps
module lpht_ctrl import lpht_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_tvalid,
	output logic in_tready,
	output logic out_tvalid,
	input  logic out_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_MOD   = 3'd2;
	localparam logic [2:0] S_HOME  = 3'd3;
	localparam logic [2:0] S_PROBE = 3'd4;
	localparam logic [2:0] S_WRITE = 3'd5;
	localparam logic [2:0] S_RESP  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_vld_q;
	logic       out_free;

	assign out_free   = !out_vld_q || out_tready;
	assign in_tready  = (state_q == S_IDLE);
	assign out_tvalid = out_vld_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_MOD;
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_done) begin
					state_d = S_HOME;
				end
			end
			S_HOME: begin
				cmd.home = 1'b1;
				state_d  = S_PROBE;
			end
			S_PROBE: begin
				cmd.probe = 1'b1;
				if (sts.hit) begin
					state_d = (sts.is_ins || sts.is_del) ? S_WRITE : S_RESP;
				end else if (sts.last) begin
					state_d = S_RESP;
				end
			end
			S_WRITE: begin
				cmd.wr  = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_vld_q <= 1'b1;
			end else if (out_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	a_accept_starts_reduction: assert property (@(posedge clk) disable iff (!arst_n)
		(in_tvalid && in_tready) |=> (state_q == S_MOD))
		else $error("accepted request did not start key reduction");

	a_hit_ends_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE && sts.hit) |=> (state_q == S_WRITE || state_q == S_RESP))
		else $error("probe kept running after a hit");

	a_miss_ends_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE && sts.last && !sts.hit) |=> (state_q == S_RESP))
		else $error("probe kept running after a full wrap");

	a_result_posted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && !out_vld_q) |=> (out_vld_q && state_q == S_IDLE))
		else $error("result not posted with an empty output register");

endmodule

// File: hdl/linear_probe_hash_table_unit.sv
`timescale 1ns / 1ps
// Flow: a transfer in is taken in idle, the key is reduced mod SLOTS by reciprocal multiply (a
// no-op if SLOTS is a power of two), then the probe reads slots from the home slot, one per cycle
// through the registered RAM read port, until a hit or SLOTS slots; insert/delete hits write back.
// One request in flight; the result posts once the output register is free, and s_axis_tready
// rises in the same cycle as m_axis_tvalid. Reset: asynchronous, active low; afterwards a
// clearing pass writes every slot empty with s_axis_tready low, and the entry count starts at zero.
module linear_probe_hash_table_unit import lpht_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // key[30:0], value[62:31], zero[63]
	input  logic [ACT_W-1:0]       s_axis_tuser,  // action[1:0]
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // read_value[31:0], entry_total[38:32], zero[39]
	output logic [STAT_W-1:0]      m_axis_tuser   // status[1:0]
);

	cmd_t cmd;
	sts_t sts;

	lpht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tvalid (s_axis_tvalid),
		.in_tready (s_axis_tready),
		.out_tvalid(m_axis_tvalid),
		.out_tready(m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lpht_dp #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_tuser (s_axis_tuser),
		.in_tdata (s_axis_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.out_tuser(m_axis_tuser),
		.out_tdata(m_axis_tdata)
	);

endmodule
